/* hw/rtl/hsvrgb_pkg.sv */
// hsvrgb_pkg: shared types and constants of the HSV to RGBA converter.
// Item structs for both channels, hue sector codes, default fraction width.
// No dependencies.
`default_nettype none

package hsvrgb_pkg;

	// default number of fraction bits in the fixed point arithmetic
	localparam int FRAC_BITS_DEF = 16;

	// input item: hue, saturation, value and alpha
	typedef struct packed {
		logic [15:0] hue_in;
		logic [16:0] sat_in;
		logic [16:0] val_in;
		logic [7:0]  alpha_in;
	} hsv_item_t;

	// result item: one RGBA pixel
	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic [7:0] alpha_out;
	} rgb_item_t;

	// hue sectors of 60 degrees each
	typedef enum logic [2:0] {
		SEC_RED_YEL = 3'd0,
		SEC_YEL_GRN = 3'd1,
		SEC_GRN_CYN = 3'd2,
		SEC_CYN_BLU = 3'd3,
		SEC_BLU_MAG = 3'd4,
		SEC_MAG_RED = 3'd5
	} sector_t;

endpackage

`default_nettype wire

/* hw/rtl/hsv_to_rgb_converter.sv */
// hsv_to_rgb_converter: top level of the HSV to RGBA pixel converter.
// Instantiates hsvrgb_prep, hsvrgb_mul and hsvrgb_out; uses hsvrgb_pkg.
//
// Converts one HSV item with alpha into one RGBA pixel in FRAC_BITS fixed
// point. The block is a four stage pipeline (clamp and sector split, first
// products, second products, channel routing and scaling by 255) and takes
// one item every clock cycle unless the full pipeline is held by rgb_stall;
// a result is presented from the stage 4 register after its item has passed
// the stage 1 to 3 registers, two of them dependent multiplier stages. Each stage
// has its own valid bit and moves whenever its successor has room, so empty
// slots close up while rgb_stall is high and the input keeps accepting items
// until the pipeline is full. alpha passes through unchanged.
`default_nettype none

module hsv_to_rgb_converter #(
	parameter int FRAC_BITS = hsvrgb_pkg::FRAC_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  hsv_valid,
	output logic                       hsv_stall,
	input  wire hsvrgb_pkg::hsv_item_t hsv_item,
	output logic                       rgb_valid,
	input  wire logic                  rgb_stall,
	output hsvrgb_pkg::rgb_item_t      rgb_item
);

	logic vld_s1;
	logic vld_s2;
	logic vld_s3;
	logic vld_s4;
	logic en1;
	logic en2;
	logic en3;
	logic en4;

	hsvrgb_pkg::sector_t    sector_s1;
	logic                   grey_s1;
	logic [FRAC_BITS-1:0]   f_s1;
	logic [FRAC_BITS:0]     omf_s1;
	logic [FRAC_BITS:0]     s_s1;
	logic [FRAC_BITS:0]     oms_s1;
	logic [FRAC_BITS:0]     v_s1;
	logic [7:0]             alpha_s1;
	hsvrgb_pkg::sector_t    sector_s3;
	logic                   grey_s3;
	logic [FRAC_BITS:0]     v_s3;
	logic [FRAC_BITS:0]     p_s3;
	logic [2*FRAC_BITS+1:0] qprod_s3;
	logic [2*FRAC_BITS+1:0] tprod_s3;
	logic [7:0]             alpha_s3;

	// stage enables: a stage loads when it is empty or its successor moves
	assign en4 = !vld_s4 || !rgb_stall;
	assign en3 = !vld_s3 || en4;
	assign en2 = !vld_s2 || en3;
	assign en1 = !vld_s1 || en2;

	assign hsv_stall = !en1;
	assign rgb_valid = vld_s4;

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= hsv_valid;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
			if (en4) vld_s4 <= vld_s3;
		end
	end

	hsvrgb_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
		.clk       (clk),
		.en        (en1),
		.item      (hsv_item),
		.sector_s1 (sector_s1),
		.grey_s1   (grey_s1),
		.f_s1      (f_s1),
		.omf_s1    (omf_s1),
		.s_s1      (s_s1),
		.oms_s1    (oms_s1),
		.v_s1      (v_s1),
		.alpha_s1  (alpha_s1)
	);

	hsvrgb_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
		.clk       (clk),
		.en2       (en2),
		.en3       (en3),
		.sector_s1 (sector_s1),
		.grey_s1   (grey_s1),
		.f_s1      (f_s1),
		.omf_s1    (omf_s1),
		.s_s1      (s_s1),
		.oms_s1    (oms_s1),
		.v_s1      (v_s1),
		.alpha_s1  (alpha_s1),
		.sector_s3 (sector_s3),
		.grey_s3   (grey_s3),
		.v_s3      (v_s3),
		.p_s3      (p_s3),
		.qprod_s3  (qprod_s3),
		.tprod_s3  (tprod_s3),
		.alpha_s3  (alpha_s3)
	);

	hsvrgb_out #(.FRAC_BITS(FRAC_BITS)) u_out (
		.clk       (clk),
		.en        (en4),
		.sector_s3 (sector_s3),
		.grey_s3   (grey_s3),
		.v_s3      (v_s3),
		.p_s3      (p_s3),
		.qprod_s3  (qprod_s3),
		.tprod_s3  (tprod_s3),
		.alpha_s3  (alpha_s3),
		.item_s4   (rgb_item)
	);

endmodule

`default_nettype wire

/* hw/rtl/hsvrgb_prep.sv */
// hsvrgb_prep: stage 1, range clamping, hue sector split and complements.
// Depends on hsvrgb_pkg.
`default_nettype none

module hsvrgb_prep #(
	parameter int FRAC_BITS = hsvrgb_pkg::FRAC_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  en,
	input  wire hsvrgb_pkg::hsv_item_t item,
	output hsvrgb_pkg::sector_t        sector_s1,
	output logic                       grey_s1,
	output logic [FRAC_BITS-1:0]       f_s1,
	output logic [FRAC_BITS:0]         omf_s1,
	output logic [FRAC_BITS:0]         s_s1,
	output logic [FRAC_BITS:0]         oms_s1,
	output logic [FRAC_BITS:0]         v_s1,
	output logic [7:0]                 alpha_s1
);

	localparam int EW = FRAC_BITS + 18;
	localparam logic [EW-1:0] ONE_W = {{(EW-1){1'b0}}, 1'b1} << FRAC_BITS;
	localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

	logic [EW-1:0]        hue_w;
	logic [EW-1:0]        sat_w;
	logic [EW-1:0]        val_w;
	logic [FRAC_BITS-1:0] hue_c;
	logic [FRAC_BITS:0]   sat_c;
	logic [FRAC_BITS:0]   val_c;
	logic [FRAC_BITS+2:0] h6;
	logic [FRAC_BITS-1:0] frac;

	// clamp: hue of a full turn or more wraps to zero, s and v saturate at one
	always_comb begin
		hue_w = EW'(item.hue_in);
		sat_w = EW'(item.sat_in);
		val_w = EW'(item.val_in);
		hue_c = (hue_w >= ONE_W) ? '0 : hue_w[FRAC_BITS-1:0];
		sat_c = (sat_w > ONE_W) ? ONE : sat_w[FRAC_BITS:0];
		val_c = (val_w > ONE_W) ? ONE : val_w[FRAC_BITS:0];
	end

	// hue * 6 as shift and add; integer part is the sector
	assign h6   = (FRAC_BITS+3)'({hue_c, 2'b00}) + (FRAC_BITS+3)'({hue_c, 1'b0});
	assign frac = h6[FRAC_BITS-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			sector_s1 <= hsvrgb_pkg::sector_t'(h6[FRAC_BITS+2:FRAC_BITS]);
			grey_s1   <= (sat_c == '0);
			f_s1      <= frac;
			omf_s1    <= ONE - {1'b0, frac};
			s_s1      <= sat_c;
			oms_s1    <= ONE - sat_c;
			v_s1      <= val_c;
			alpha_s1  <= item.alpha_in;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/hsvrgb_mul.sv */
// hsvrgb_mul: stages 2 and 3, the products that form p, q and t.
// Stage 2: v*(1-s), s*f, s*(1-f). Stage 3: v*(1-s*f), v*(1-s*(1-f)).
// Depends on hsvrgb_pkg.
`default_nettype none

module hsvrgb_mul #(
	parameter int FRAC_BITS = hsvrgb_pkg::FRAC_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  en2,
	input  wire logic                  en3,
	input  wire hsvrgb_pkg::sector_t   sector_s1,
	input  wire logic                  grey_s1,
	input  wire logic [FRAC_BITS-1:0]  f_s1,
	input  wire logic [FRAC_BITS:0]    omf_s1,
	input  wire logic [FRAC_BITS:0]    s_s1,
	input  wire logic [FRAC_BITS:0]    oms_s1,
	input  wire logic [FRAC_BITS:0]    v_s1,
	input  wire logic [7:0]            alpha_s1,
	output hsvrgb_pkg::sector_t        sector_s3,
	output logic                       grey_s3,
	output logic [FRAC_BITS:0]         v_s3,
	output logic [FRAC_BITS:0]         p_s3,
	output logic [2*FRAC_BITS+1:0]     qprod_s3,
	output logic [2*FRAC_BITS+1:0]     tprod_s3,
	output logic [7:0]                 alpha_s3
);

	localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

	hsvrgb_pkg::sector_t    sector_s2;
	logic                   grey_s2;
	logic [FRAC_BITS:0]     v_s2;
	logic [2*FRAC_BITS+1:0] pprod_s2;
	logic [2*FRAC_BITS:0]   sf_s2;
	logic [2*FRAC_BITS+1:0] st_s2;
	logic [7:0]             alpha_s2;
	logic [FRAC_BITS:0]     qa;
	logic [FRAC_BITS:0]     ta;

	// stage 2: first products
	always_ff @(posedge clk) begin
		if (en2) begin
			sector_s2 <= sector_s1;
			grey_s2   <= grey_s1;
			v_s2      <= v_s1;
			pprod_s2  <= v_s1 * oms_s1;
			sf_s2     <= s_s1 * f_s1;
			st_s2     <= s_s1 * omf_s1;
			alpha_s2  <= alpha_s1;
		end
	end

	// complements of the scaled saturation terms; s*f stays below one
	assign qa = ONE - {1'b0, sf_s2[2*FRAC_BITS-1:FRAC_BITS]};
	assign ta = ONE - st_s2[2*FRAC_BITS:FRAC_BITS];

	// stage 3: second products, p is finished here
	always_ff @(posedge clk) begin
		if (en3) begin
			sector_s3 <= sector_s2;
			grey_s3   <= grey_s2;
			v_s3      <= v_s2;
			p_s3      <= pprod_s2[2*FRAC_BITS:FRAC_BITS];
			qprod_s3  <= v_s2 * qa;
			tprod_s3  <= v_s2 * ta;
			alpha_s3  <= alpha_s2;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/hsvrgb_out.sv */
// hsvrgb_out: stage 4, sector routing of v, p, q, t and byte scaling by 255.
// Holds the output register of the pipeline. Depends on hsvrgb_pkg.
`default_nettype none

module hsvrgb_out #(
	parameter int FRAC_BITS = hsvrgb_pkg::FRAC_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  en,
	input  wire hsvrgb_pkg::sector_t   sector_s3,
	input  wire logic                  grey_s3,
	input  wire logic [FRAC_BITS:0]    v_s3,
	input  wire logic [FRAC_BITS:0]    p_s3,
	input  wire logic [2*FRAC_BITS+1:0] qprod_s3,
	input  wire logic [2*FRAC_BITS+1:0] tprod_s3,
	input  wire logic [7:0]            alpha_s3,
	output hsvrgb_pkg::rgb_item_t      item_s4
);

	logic [FRAC_BITS:0] q;
	logic [FRAC_BITS:0] t;
	logic [FRAC_BITS:0] r;
	logic [FRAC_BITS:0] g;
	logic [FRAC_BITS:0] b;

	// (x*255) >> FRAC_BITS, x never above one
	function automatic logic [7:0] to_byte(input logic [FRAC_BITS:0] x);
		logic [FRAC_BITS+8:0] m;
		m = {x, 8'b0} - (FRAC_BITS+9)'(x);
		return m[FRAC_BITS+7:FRAC_BITS];
	endfunction

	assign q = qprod_s3[2*FRAC_BITS:FRAC_BITS];
	assign t = tprod_s3[2*FRAC_BITS:FRAC_BITS];

	// route channels by sector; zero saturation gives grey
	always_comb begin
		if (grey_s3) begin
			r = v_s3;
			g = v_s3;
			b = v_s3;
		end else begin
			case (sector_s3)
				hsvrgb_pkg::SEC_RED_YEL: begin r = v_s3; g = t;    b = p_s3; end
				hsvrgb_pkg::SEC_YEL_GRN: begin r = q;    g = v_s3; b = p_s3; end
				hsvrgb_pkg::SEC_GRN_CYN: begin r = p_s3; g = v_s3; b = t;    end
				hsvrgb_pkg::SEC_CYN_BLU: begin r = p_s3; g = q;    b = v_s3; end
				hsvrgb_pkg::SEC_BLU_MAG: begin r = t;    g = p_s3; b = v_s3; end
				default:                 begin r = v_s3; g = p_s3; b = q;    end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s4.red_out   <= to_byte(r);
			item_s4.green_out <= to_byte(g);
			item_s4.blue_out  <= to_byte(b);
			item_s4.alpha_out <= alpha_s3;
		end
	end

endmodule

`default_nettype wire
